FILE: rtl/aabb_affine_transform_macros.svh
// ----------------------------------------------------------------------------
// aabb affine transform assertion macros
// shared property forms for the box transform assertions
// ----------------------------------------------------------------------------
`ifndef AABB_AFFINE_TRANSFORM_MACROS_SVH
`define AABB_AFFINE_TRANSFORM_MACROS_SVH

// same-cycle implication
`define AAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg
// register indexes and fixed constants of the box transform
// ----------------------------------------------------------------------------
package aat_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int NUM_AXES   = 3;
    localparam int PIPE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X   = 3'd0,
        CFG_ROW_Y   = 3'd1,
        CFG_ROW_Z   = 3'd2,
        CFG_SHIFT_X = 3'd3,
        CFG_SHIFT_Y = 3'd4,
        CFG_SHIFT_Z = 3'd5
    } t_cfg_idx;

endpackage

FILE: rtl/aabb_affine_transform.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform
// axis-aligned box through a 3x3 matrix plus translation, re-boxed
// ----------------------------------------------------------------------------
// Takes one box per cycle and returns one box per cycle while the output is
// not stalled, through a four-stage pipeline: products, per-coefficient
// min/max selection, three-term sum with rounding, then rescale, translation
// and clamping into the output register. Because the mapping is monotone in
// each coordinate, the extreme corners come from picking, for every product,
// the smaller or larger of the lower and upper coordinate, so 18 multipliers
// of COEF_WIDTH x COORD_WIDTH bits serve all eight corners. Backpressure
// ripples through the stages, so bubbles are filled while the output waits.
// Configuration writes are always ready and take effect at once; write them
// only while the pipeline is empty.
// ----------------------------------------------------------------------------
`include "aabb_affine_transform_macros.svh"

module aabb_affine_transform #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16,
    localparam int ROW_W = (3 * COEF_WIDTH > 64) ? 64 : 3 * COEF_WIDTH,
    localparam int CFG_W = (ROW_W > COORD_WIDTH) ? ROW_W : COORD_WIDTH,
    localparam int TD_W  = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [aat_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]               i_cfg_data,
    // box in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // lower_x, lower_y, lower_z, upper_x, upper_y, upper_z
    input  logic [TD_W-1:0]                s_axis_tdata,
    // box out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // new_lower_x, new_lower_y, new_lower_z, new_upper_x, new_upper_y, new_upper_z
    output logic [TD_W-1:0]                m_axis_tdata,
    // saturated
    output logic [0:0]                     m_axis_tuser
);

    import aat_pkg::*;

    localparam int COEF_FRAC = COEF_WIDTH - 2;
    localparam int ROW_FULL  = 3 * COEF_WIDTH;
    localparam int PW        = COEF_WIDTH + COORD_WIDTH;
    localparam int SW        = PW + 1;
    localparam int VW        = COORD_WIDTH + 4;
    localparam int FW        = 6 * COORD_WIDTH;

    localparam logic signed [SW-1:0] RND  = SW'(1) << (COEF_FRAC - 1);
    localparam logic signed [VW-1:0] VMAX =
        {{(VW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = ~VMAX;

    // configuration registers
    logic [ROW_W-1:0]              r_row   [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_shift [NUM_AXES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]   <= ROW_W'(1) << COEF_FRAC;
            r_row[1]   <= ROW_W'(1) << (COEF_FRAC + COEF_WIDTH);
            r_row[2]   <= ROW_W'(1) << (COEF_FRAC + 2 * COEF_WIDTH);
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROW_X:   r_row[0]   <= i_cfg_data[ROW_W-1:0];
                CFG_ROW_Y:   r_row[1]   <= i_cfg_data[ROW_W-1:0];
                CFG_ROW_Z:   r_row[2]   <= i_cfg_data[ROW_W-1:0];
                CFG_SHIFT_X: r_shift[0] <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_SHIFT_Y: r_shift[1] <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_SHIFT_Z: r_shift[2] <= i_cfg_data[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and load enables
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] en;

    always_comb begin
        en[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || m_axis_tready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // input unpack and coefficients
    logic signed [COORD_WIDTH-1:0] in_lo [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] in_up [NUM_AXES];
    logic [ROW_FULL-1:0]           row_pad [NUM_AXES];
    logic signed [COEF_WIDTH-1:0]  coef [NUM_AXES][NUM_AXES];

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            in_lo[k] = s_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH];
            in_up[k] = s_axis_tdata[(k+3)*COORD_WIDTH +: COORD_WIDTH];
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            row_pad[a] = ROW_FULL'(r_row[a]);
            for (int k = 0; k < NUM_AXES; k++) begin
                coef[a][k] = row_pad[a][k*COEF_WIDTH +: COEF_WIDTH];
            end
        end
    end

    // stage 1: products
    logic signed [PW-1:0] r1_p_lo [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0] r1_p_up [NUM_AXES][NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int k = 0; k < NUM_AXES; k++) begin
                    r1_p_lo[a][k] <= coef[a][k] * in_lo[k];
                    r1_p_up[a][k] <= coef[a][k] * in_up[k];
                end
            end
        end
    end

    // stage 2: smaller and larger product of each term
    logic signed [PW-1:0] r2_min [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0] r2_max [NUM_AXES][NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int k = 0; k < NUM_AXES; k++) begin
                    if (r1_p_lo[a][k] < r1_p_up[a][k]) begin
                        r2_min[a][k] <= r1_p_lo[a][k];
                        r2_max[a][k] <= r1_p_up[a][k];
                    end else begin
                        r2_min[a][k] <= r1_p_up[a][k];
                        r2_max[a][k] <= r1_p_lo[a][k];
                    end
                end
            end
        end
    end

    // stage 3: sums with half lsb added
    logic signed [SW-1:0] r3_smin [NUM_AXES];
    logic signed [SW-1:0] r3_smax [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r3_smin[a] <= SW'(r2_min[a][0]) + SW'(r2_min[a][1])
                            + SW'(r2_min[a][2]) + RND;
                r3_smax[a] <= SW'(r2_max[a][0]) + SW'(r2_max[a][1])
                            + SW'(r2_max[a][2]) + RND;
            end
        end
    end

    // stage 4: rescale, translate, clamp
    logic signed [VW-1:0]          v_min [NUM_AXES];
    logic signed [VW-1:0]          v_max [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] n_lo  [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] n_hi  [NUM_AXES];
    logic                          n_sat;

    always_comb begin
        n_sat = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            v_min[a] = VW'($signed(r3_smin[a][SW-1:COEF_FRAC])) + VW'(r_shift[a]);
            v_max[a] = VW'($signed(r3_smax[a][SW-1:COEF_FRAC])) + VW'(r_shift[a]);
            if (v_min[a] > VMAX) begin
                n_lo[a] = VMAX[COORD_WIDTH-1:0];
                n_sat   = 1'b1;
            end else if (v_min[a] < VMIN) begin
                n_lo[a] = VMIN[COORD_WIDTH-1:0];
                n_sat   = 1'b1;
            end else begin
                n_lo[a] = v_min[a][COORD_WIDTH-1:0];
            end
            if (v_max[a] > VMAX) begin
                n_hi[a] = VMAX[COORD_WIDTH-1:0];
                n_sat   = 1'b1;
            end else if (v_max[a] < VMIN) begin
                n_hi[a] = VMIN[COORD_WIDTH-1:0];
                n_sat   = 1'b1;
            end else begin
                n_hi[a] = v_max[a][COORD_WIDTH-1:0];
            end
        end
    end

    logic signed [COORD_WIDTH-1:0] r_out_lo [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_out_hi [NUM_AXES];
    logic                          r_out_sat;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_out_lo  <= n_lo;
            r_out_hi  <= n_hi;
            r_out_sat <= n_sat;
        end
    end

    assign m_axis_tvalid   = r_vld[PIPE_DEPTH-1];
    assign m_axis_tuser[0] = r_out_sat;
    assign m_axis_tdata    = TD_W'(FW'({r_out_hi[2], r_out_hi[1], r_out_hi[0],
                                        r_out_lo[2], r_out_lo[1], r_out_lo[0]}));

    // assertions
    `AAT_ASSERT_NOW(a_box_ordered, m_axis_tvalid,
        (r_out_lo[0] <= r_out_hi[0]) && (r_out_lo[1] <= r_out_hi[1])
        && (r_out_lo[2] <= r_out_hi[2]), "output box has lower above upper")
    `AAT_ASSERT_NOW(a_stall_only_full, !s_axis_tready, &r_vld,
        "input stalled while a pipeline stage is empty")
    `AAT_ASSERT_NEXT(a_no_drop, r_vld[2] && !r_vld[3], r_vld[3],
        "item lost between sum and output stage")

endmodule
